// ===== rtl/imufd_pkg.sv =====
package imufd_pkg;

	localparam int APB_AW = 4;

	localparam logic [1:0] REG_SYNC  = 2'd0;
	localparam logic [1:0] REG_CHECK = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic [7:0]  SYNC_RESET  = 8'h55;
	localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

	localparam logic [7:0] TYPE_TIME  = 8'h50;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_MAG   = 8'h54;
	localparam logic [7:0] TYPE_QUAT  = 8'h59;

	localparam logic [2:0] KIND_TIME  = 3'd0;
	localparam logic [2:0] KIND_ACCEL = 3'd1;
	localparam logic [2:0] KIND_RATE  = 3'd2;
	localparam logic [2:0] KIND_ANGLE = 3'd3;
	localparam logic [2:0] KIND_MAG   = 3'd4;
	localparam logic [2:0] KIND_QUAT  = 3'd5;

	// 200*pi/9 in Q32: raw rate count to rad/s in Q16.16.
	localparam logic [38:0] RATE_K     = 39'd299845282323;
	localparam int          RATE_SPLIT = 20;

	typedef struct packed {
		logic             hit;
		logic [2:0]       kind;
		logic [3:0][15:0] words;
		logic [31:0]      now;
	} frame_item_t;

	typedef struct packed {
		logic               data_ready;
		logic               rate_ready;
		logic               quat_ready;
		logic signed [24:0] value_d;
		logic signed [24:0] value_c;
		logic signed [24:0] value_b;
		logic signed [24:0] value_a;
		logic               probe_hit;
		logic [2:0]         frame_kind;
		logic               frame_valid;
	} result_t;

endpackage

// ===== rtl/imufd_front.sv =====
module imufd_front import imufd_pkg::*; #(
	parameter int FRAME_LENGTH = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_ticks,
	input  logic [7:0]  sync_code,
	output logic        item_valid,
	input  logic        item_ready,
	output frame_item_t item
);

	localparam int FW       = $clog2(FRAME_LENGTH);
	localparam int HELD     = FRAME_LENGTH - 1;
	localparam int SUM_LVLS = $clog2(HELD);
	localparam int LEAVES   = 1 << SUM_LVLS;

	// Oldest byte at index 0, newest at the top.
	logic [7:0]    win_q [HELD];
	logic [FW-1:0] fill_q;
	logic [7:0]    node [SUM_LVLS+1][LEAVES];
	logic [7:0]    word_byte [8];
	logic          known;
	logic [2:0]    kind;
	logic          full_now;
	logic          hit;
	logic          take;

	genvar gl, gi;
	generate
		for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
			if (gi < HELD) begin : g_used
				assign node[0][gi] = win_q[gi];
			end else begin : g_pad
				assign node[0][gi] = 8'h00;
			end
		end
		for (gl = 0; gl < SUM_LVLS; gl++) begin : g_lvl
			for (gi = 0; gi < (LEAVES >> (gl + 1)); gi++) begin : g_add
				assign node[gl+1][gi] = node[gl][2*gi] + node[gl][2*gi+1];
			end
		end
		for (gi = 0; gi < 8; gi++) begin : g_wb
			if (gi + 2 < HELD) begin : g_held
				assign word_byte[gi] = win_q[gi+2];
			end else begin : g_new
				assign word_byte[gi] = rx_byte;
			end
		end
	endgenerate

	always_comb begin
		known = 1'b1;
		kind  = KIND_TIME;
		unique case (win_q[1])
			TYPE_TIME:  kind = KIND_TIME;
			TYPE_ACCEL: kind = KIND_ACCEL;
			TYPE_RATE:  kind = KIND_RATE;
			TYPE_ANGLE: kind = KIND_ANGLE;
			TYPE_MAG:   kind = KIND_MAG;
			TYPE_QUAT:  kind = KIND_QUAT;
			default:    known = 1'b0;
		endcase
	end

	assign full_now = (fill_q == FW'(HELD));
	assign hit      = full_now && (win_q[0] == sync_code)
		&& (node[SUM_LVLS][0] == rx_byte) && known;

	assign in_ready   = item_ready;
	assign item_valid = in_valid;
	assign take       = in_valid && item_ready;

	always_comb begin
		item.hit  = hit;
		item.kind = hit ? kind : KIND_TIME;
		for (int i = 0; i < 4; i++) begin
			item.words[i] = {word_byte[2*i+1], word_byte[2*i]};
		end
		item.now = now_ticks;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < HELD - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[HELD-1] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (take) begin
			if (hit) begin
				fill_q <= '0;
			end else if (!full_now) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

endmodule

// ===== rtl/imufd_queue.sv =====
module imufd_queue import imufd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  frame_item_t in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output frame_item_t out_item
);

	frame_item_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/imufd_back.sv =====
module imufd_back import imufd_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  frame_item_t item,
	input  logic        staleness_check,
	input  logic [31:0] staleness_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     result
);

	localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam logic signed [19:0] K_HI = {1'b0, RATE_K[38:RATE_SPLIT]};
	localparam logic signed [20:0] K_LO = {1'b0, RATE_K[RATE_SPLIT-1:0]};
	localparam logic signed [56:0] RND  = 57'sd2147483648;

	logic                 v_s1;
	logic                 hit_s1;
	logic [2:0]           kind_s1;
	logic signed [24:0]   simple_s1 [4];
	logic signed [35:0]   ph_s1 [4];
	logic signed [36:0]   pl_s1 [4];
	logic                 qseen_s1;
	logic                 rseen_s1;
	logic [TIME_BITS-1:0] qage_s1;
	logic [TIME_BITS-1:0] rage_s1;

	logic                 v_s2;
	result_t              res_s2;

	logic                 qseen_q;
	logic                 rseen_q;
	logic [TIME_BITS-1:0] qtime_q;
	logic [TIME_BITS-1:0] rtime_q;

	logic                 take_s1;
	logic                 take_s2;
	logic                 is_rate;
	logic                 is_quat;
	logic [TIME_BITS-1:0] now_t;
	logic signed [15:0]   d [4];
	logic signed [24:0]   simple [4];
	logic signed [35:0]   ph [4];
	logic signed [36:0]   pl [4];
	logic signed [56:0]   rsum [4];
	logic signed [24:0]   val [4];
	logic                 age_ok;
	result_t              res_next;

	assign take_s2  = !v_s2 || out_ready;
	assign in_ready = !v_s1 || take_s2;
	assign take_s1  = in_valid && in_ready;

	assign now_t   = TIME_BITS'(item.now);
	assign is_rate = item.hit && (item.kind == KIND_RATE);
	assign is_quat = item.hit && (item.kind == KIND_QUAT);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			d[i]      = signed'(item.words[i]);
			ph[i]     = 36'(d[i]) * 36'(K_HI);
			pl[i]     = 37'(d[i]) * 37'(K_LO);
			simple[i] = '0;
			if (item.hit) begin
				unique case (item.kind)
					KIND_ACCEL: if (i < 3) simple[i] = 25'(d[i]) <<< 5;
					KIND_ANGLE: if (i < 3) simple[i] = 25'(d[i]) * 25'sd360;
					KIND_QUAT:  simple[i] = 25'(d[i]) <<< 1;
					default:    simple[i] = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			hit_s1   <= item.hit;
			kind_s1  <= item.kind;
			qseen_s1 <= qseen_q || is_quat;
			rseen_s1 <= rseen_q || is_rate;
			qage_s1  <= is_quat ? '0 : now_t - qtime_q;
			rage_s1  <= is_rate ? '0 : now_t - rtime_q;
			for (int i = 0; i < 4; i++) begin
				simple_s1[i] <= simple[i];
				ph_s1[i]     <= ph[i];
				pl_s1[i]     <= pl[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			qseen_q <= 1'b0;
			rseen_q <= 1'b0;
			qtime_q <= '0;
			rtime_q <= '0;
		end else begin
			if (take_s1) begin
				v_s1 <= 1'b1;
				if (is_rate) begin
					rseen_q <= 1'b1;
					rtime_q <= now_t;
				end
				if (is_quat) begin
					qseen_q <= 1'b1;
					qtime_q <= now_t;
				end
			end else if (take_s2) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rsum[i] = (57'(ph_s1[i]) <<< RATE_SPLIT) + 57'(pl_s1[i]) + RND;
			if (hit_s1 && (kind_s1 == KIND_RATE) && (i < 3)) begin
				val[i] = rsum[i][56:32];
			end else begin
				val[i] = simple_s1[i];
			end
		end
		age_ok = (CW'(qage_s1) <= CW'(staleness_limit))
			&& (CW'(rage_s1) <= CW'(staleness_limit));
		res_next.frame_valid = hit_s1;
		res_next.frame_kind  = hit_s1 ? kind_s1 : KIND_TIME;
		res_next.probe_hit   = hit_s1 && (kind_s1 != KIND_TIME);
		res_next.value_a     = val[0];
		res_next.value_b     = val[1];
		res_next.value_c     = val[2];
		res_next.value_d     = val[3];
		res_next.quat_ready  = qseen_s1;
		res_next.rate_ready  = rseen_s1;
		res_next.data_ready  = qseen_s1 && rseen_s1 && (!staleness_check || age_ok);
	end

	always_ff @(posedge clk) begin
		if (take_s2 && v_s1) begin
			res_s2 <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (take_s2) begin
			v_s2 <= v_s1;
		end
	end

	assign out_valid = v_s2;
	assign result    = res_s2;

endmodule

// ===== rtl/imu_sensor_frame_deframer.sv =====
// Path: an input word passes the byte window and checksum tree, a two-entry
// queue, then the two-stage scaling pipeline. Throughput: one input word per
// cycle while m_tready is high; back-pressure fills the queue and stalls input.
// Reset: arst_n clears the window fill, ready flags, stored times and all
// handshake state, and returns the registers to their reset values.
module imu_sensor_frame_deframer import imufd_pkg::*; #(
	parameter int FRAME_LENGTH = 11,
	parameter int TIME_BITS    = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// [7:0] rx_byte, [39:8] now_ticks
	input  logic [39:0]       s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// [24:0] value_a, [49:25] value_b, [74:50] value_c, [99:75] value_d,
	// [100] quat_ready, [101] rate_ready, [102] data_ready, [103] zero
	output logic [103:0]      m_tdata,
	// [0] frame_valid, [3:1] frame_kind, [4] probe_hit
	output logic [4:0]        m_tuser,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [7:0]  sync_q;
	logic        check_q;
	logic [31:0] limit_q;
	logic        wr_en;

	frame_item_t front_item;
	logic        front_valid;
	logic        queue_ready;
	frame_item_t back_item;
	logic        back_valid;
	logic        back_ready;
	result_t     res;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q  <= SYNC_RESET;
			check_q <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SYNC:  sync_q  <= pwdata[7:0];
				REG_CHECK: check_q <= pwdata[0];
				REG_LIMIT: limit_q <= pwdata;
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SYNC:  prdata = {24'd0, sync_q};
			REG_CHECK: prdata = {31'd0, check_q};
			REG_LIMIT: prdata = limit_q;
			default:   prdata = 32'd0;
		endcase
	end

	imufd_front #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.rx_byte    (s_tdata[7:0]),
		.now_ticks  (s_tdata[39:8]),
		.sync_code  (sync_q),
		.item_valid (front_valid),
		.item_ready (queue_ready),
		.item       (front_item)
	);

	imufd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (queue_ready),
		.in_item   (front_item),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_item  (back_item)
	);

	imufd_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (back_valid),
		.in_ready        (back_ready),
		.item            (back_item),
		.staleness_check (check_q),
		.staleness_limit (limit_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.result          (res)
	);

	assign m_tdata = {1'b0, res.data_ready, res.rate_ready, res.quat_ready,
		res.value_d, res.value_c, res.value_b, res.value_a};
	assign m_tuser = {res.probe_hit, res.frame_kind, res.frame_valid};

endmodule
